@@ rtl/ra_pkg.sv @@
`default_nettype none
package ra_pkg;

	localparam int FIELD_W   = 32;
	localparam int DEN_W     = 31;
	localparam int WIDTH_DEF = 32;
	localparam int WIDE_W    = 64;

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ADD  = 2'd1;
	localparam logic [1:0] CMD_ABS  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_ZERO = 2'd1;
	localparam logic [1:0] ST_OVF  = 2'd2;

	typedef logic [3:0] op_t;
	localparam op_t OP_NOP       = 4'd0;
	localparam op_t OP_CAPTURE   = 4'd1;
	localparam op_t OP_LOAD      = 4'd2;
	localparam op_t OP_MUL1      = 4'd3;
	localparam op_t OP_MUL2      = 4'd4;
	localparam op_t OP_MUL3      = 4'd5;
	localparam op_t OP_PREP      = 4'd6;
	localparam op_t OP_GCD_BOTH  = 4'd7;
	localparam op_t OP_GCD_A     = 4'd8;
	localparam op_t OP_GCD_STEP  = 4'd9;
	localparam op_t OP_DIV_INIT  = 4'd10;
	localparam op_t OP_DIV       = 4'd11;
	localparam op_t OP_STORE     = 4'd12;
	localparam op_t OP_ABS       = 4'd13;
	localparam op_t OP_REJECT    = 4'd14;
	localparam op_t OP_REPLY_OK  = 4'd15;

	typedef struct packed {
		logic [1:0] cmd;
		logic       den_zero;
		logic       both_even;
		logic       a_even;
		logic       b_zero;
		logic       div_last;
		logic       out_free;
	} stat_t;

endpackage
`default_nettype wire

@@ rtl/ra_ctrl.sv @@
`default_nettype none
module ra_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	output logic           in_stall,
	input  ra_pkg::stat_t  stat,
	output ra_pkg::op_t    op
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_MUL2     = 4'd2;
	localparam logic [3:0] S_MUL3     = 4'd3;
	localparam logic [3:0] S_PREP     = 4'd4;
	localparam logic [3:0] S_GCD_BOTH = 4'd5;
	localparam logic [3:0] S_GCD_A    = 4'd6;
	localparam logic [3:0] S_GCD_LOOP = 4'd7;
	localparam logic [3:0] S_DIV      = 4'd8;
	localparam logic [3:0] S_STORE    = 4'd9;
	localparam logic [3:0] S_REPLY    = 4'd10;
	localparam logic [3:0] S_REPLY2   = 4'd11;

	logic [3:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		op      = ra_pkg::OP_NOP;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = ra_pkg::OP_CAPTURE;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					ra_pkg::CMD_LOAD: begin
						op      = stat.den_zero ? ra_pkg::OP_REJECT : ra_pkg::OP_LOAD;
						state_d = stat.den_zero ? S_REPLY : S_PREP;
					end
					ra_pkg::CMD_ADD: begin
						op      = stat.den_zero ? ra_pkg::OP_REJECT : ra_pkg::OP_MUL1;
						state_d = stat.den_zero ? S_REPLY : S_MUL2;
					end
					ra_pkg::CMD_ABS: begin
						op      = ra_pkg::OP_ABS;
						state_d = S_REPLY;
					end
					default: begin
						state_d = S_REPLY2;
					end
				endcase
			end
			S_MUL2: begin
				op      = ra_pkg::OP_MUL2;
				state_d = S_MUL3;
			end
			S_MUL3: begin
				op      = ra_pkg::OP_MUL3;
				state_d = S_PREP;
			end
			S_PREP: begin
				op      = ra_pkg::OP_PREP;
				state_d = S_GCD_BOTH;
			end
			S_GCD_BOTH: begin
				if (stat.both_even) op = ra_pkg::OP_GCD_BOTH;
				else state_d = S_GCD_A;
			end
			S_GCD_A: begin
				if (stat.a_even) op = ra_pkg::OP_GCD_A;
				else state_d = S_GCD_LOOP;
			end
			S_GCD_LOOP: begin
				if (stat.b_zero) begin
					op      = ra_pkg::OP_DIV_INIT;
					state_d = S_DIV;
				end else begin
					op = ra_pkg::OP_GCD_STEP;
				end
			end
			S_DIV: begin
				op = ra_pkg::OP_DIV;
				if (stat.div_last) state_d = S_STORE;
			end
			S_STORE: begin
				op      = ra_pkg::OP_STORE;
				state_d = S_REPLY;
			end
			S_REPLY: begin
				// status already set by the command
				if (stat.out_free) begin
					op      = ra_pkg::OP_NOP;
					state_d = S_IDLE;
				end
			end
			S_REPLY2: begin
				if (stat.out_free) begin
					op      = ra_pkg::OP_REPLY_OK;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule
`default_nettype wire

@@ rtl/ra_dp.sv @@
`default_nettype none
module ra_dp #(
	parameter int WIDTH = ra_pkg::WIDTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  ra_pkg::op_t                        op,
	input  wire                                reply,
	output ra_pkg::stat_t                      stat,
	input  wire  [1:0]                         cmd,
	input  wire  signed [ra_pkg::FIELD_W-1:0]  operand_numerator,
	input  wire  signed [ra_pkg::FIELD_W-1:0]  operand_denominator,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [ra_pkg::FIELD_W-1:0]  result_numerator,
	output logic [ra_pkg::DEN_W-1:0]           result_denominator,
	output logic [1:0]                         status
);

	localparam int WW = ra_pkg::WIDE_W;
	localparam logic [WW-1:0] LIM = WW'(1) << (WIDTH - 1);

	logic [1:0]                        cmd_q;
	logic signed [ra_pkg::FIELD_W-1:0] on_q, od_q;
	logic signed [WIDTH-1:0]           sn_q;
	logic [WIDTH-2:0]                  sd_q;
	logic [1:0]                        st_q;
	logic signed [WW-1:0]              p_q, num_q;
	logic [WW-1:0]                     a_q, b_q, g_q;
	logic [WW-1:0]                     rn_q, rd_q, qn_q, qd_q;
	logic [5:0]                        sh_q, cnt_q;
	logic                              neg_q;
	logic                              out_valid_q;

	logic signed [32:0] ma, mb, sd33;
	logic signed [65:0] mprod;
	logic [WW-1:0]      mag_n, mag_d;
	logic [WW:0]        tn, td, gx;
	logic               gen_n, gen_d;
	logic               neg_eff, ovf;
	logic               sn_min;
	logic               out_free;

	assign sd33  = $signed({1'b0, 32'(sd_q)});
	assign mprod = ma * mb;

	always_comb begin
		ma = 33'(sn_q);
		mb = 33'(od_q);
		case (op)
			ra_pkg::OP_MUL2: begin
				ma = sd33;
				mb = 33'(on_q);
			end
			ra_pkg::OP_MUL3: begin
				ma = sd33;
				mb = 33'(od_q);
			end
			default: ;
		endcase
	end

	assign mag_n = num_q[WW-1] ? WW'(-num_q) : WW'(num_q);
	assign mag_d = p_q[WW-1] ? WW'(-p_q) : WW'(p_q);

	// restoring division, one quotient bit per cycle for both parts
	assign gx    = {1'b0, g_q};
	assign tn    = {rn_q, qn_q[WW-1]};
	assign td    = {rd_q, qd_q[WW-1]};
	assign gen_n = (tn >= gx);
	assign gen_d = (td >= gx);

	assign neg_eff = neg_q && (qn_q != '0);
	assign ovf     = (qd_q > LIM - 1'b1) || (neg_eff ? (qn_q > LIM) : (qn_q > LIM - 1'b1));
	assign sn_min  = sn_q[WIDTH-1] && (sn_q[WIDTH-2:0] == '0);

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		stat.cmd       = cmd_q;
		stat.den_zero  = (od_q == '0);
		stat.both_even = !a_q[0] && !b_q[0];
		stat.a_even    = !a_q[0];
		stat.b_zero    = (b_q == '0);
		stat.div_last  = (cnt_q == 6'(WW - 1));
		stat.out_free  = out_free;
	end

	// operands and working registers
	always_ff @(posedge clk) begin
		case (op)
			ra_pkg::OP_CAPTURE: begin
				cmd_q <= cmd;
				on_q  <= operand_numerator;
				od_q  <= operand_denominator;
			end
			ra_pkg::OP_LOAD: begin
				num_q <= WW'(on_q);
				p_q   <= WW'(od_q);
			end
			ra_pkg::OP_MUL1: p_q <= WW'(mprod);
			ra_pkg::OP_MUL2: begin
				num_q <= p_q;
				p_q   <= WW'(mprod);
			end
			ra_pkg::OP_MUL3: begin
				num_q <= num_q + p_q;
				p_q   <= WW'(mprod);
			end
			ra_pkg::OP_PREP: begin
				neg_q <= (num_q[WW-1] != p_q[WW-1]);
				sh_q  <= '0;
				// zero numerator: the gcd is the denominator itself
				if (mag_n == '0) begin
					a_q <= mag_d;
					b_q <= '0;
				end else begin
					a_q <= mag_n;
					b_q <= mag_d;
				end
			end
			ra_pkg::OP_GCD_BOTH: begin
				a_q  <= a_q >> 1;
				b_q  <= b_q >> 1;
				sh_q <= sh_q + 6'd1;
			end
			ra_pkg::OP_GCD_A: a_q <= a_q >> 1;
			ra_pkg::OP_GCD_STEP: begin
				if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q > b_q) begin
					a_q <= b_q;
					b_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			ra_pkg::OP_DIV_INIT: begin
				g_q   <= a_q << sh_q;
				rn_q  <= '0;
				rd_q  <= '0;
				qn_q  <= mag_n;
				qd_q  <= mag_d;
				cnt_q <= '0;
			end
			ra_pkg::OP_DIV: begin
				rn_q  <= gen_n ? WW'(tn - gx) : tn[WW-1:0];
				rd_q  <= gen_d ? WW'(td - gx) : td[WW-1:0];
				qn_q  <= {qn_q[WW-2:0], gen_n};
				qd_q  <= {qd_q[WW-2:0], gen_d};
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end

	// stored fraction, status and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sn_q        <= '0;
			sd_q        <= (WIDTH-1)'(1);
			st_q        <= ra_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			case (op)
				ra_pkg::OP_REJECT: st_q <= ra_pkg::ST_ZERO;
				ra_pkg::OP_REPLY_OK: st_q <= ra_pkg::ST_OK;
				ra_pkg::OP_ABS: begin
					if (sn_min) begin
						st_q <= ra_pkg::ST_OVF;
					end else begin
						st_q <= ra_pkg::ST_OK;
						if (sn_q[WIDTH-1]) sn_q <= -sn_q;
					end
				end
				ra_pkg::OP_STORE: begin
					if (ovf) begin
						st_q <= ra_pkg::ST_OVF;
					end else begin
						st_q <= ra_pkg::ST_OK;
						sn_q <= WIDTH'(neg_eff ? -qn_q : qn_q);
						sd_q <= (WIDTH-1)'(qd_q);
					end
				end
				default: ;
			endcase
			if (reply) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (reply) begin
			result_numerator   <= ra_pkg::FIELD_W'(sn_q);
			result_denominator <= ra_pkg::DEN_W'(sd_q);
			status             <= (op == ra_pkg::OP_REPLY_OK) ? ra_pkg::ST_OK : st_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		sd_q != '0) else $error("stored denominator is zero");
	a_gcd_a_odd: assert property (@(posedge clk) disable iff (!arst_n)
		(op == ra_pkg::OP_GCD_STEP) |-> a_q[0]) else $error("gcd step with even a");
	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(op == ra_pkg::OP_DIV_INIT) |=> (g_q != '0)) else $error("zero divisor");
	a_reply_free: assert property (@(posedge clk) disable iff (!arst_n)
		reply |-> out_free) else $error("reply overwrites pending result");
`endif

endmodule
`default_nettype wire

@@ rtl/rational_accumulator.sv @@
// Abs, cmd 3 and zero-denominator rejects go from decode straight to a reply state.
// Load and add run a binary gcd (one step per cycle) and a restoring division over 64 bits;
// add first runs three multiplies to bring both fractions to a common denominator.
// Throughput: one transaction at a time; in_stall stays high until the result is registered.
// Reset (arst_n low): fraction set to 0/1, output register emptied, controller idle.
`default_nettype none
module rational_accumulator #(
	parameter int WIDTH = ra_pkg::WIDTH_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [1:0]                         cmd,
	input  wire  signed [ra_pkg::FIELD_W-1:0]  operand_numerator,
	input  wire  signed [ra_pkg::FIELD_W-1:0]  operand_denominator,
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic signed [ra_pkg::FIELD_W-1:0]  result_numerator,
	output logic [ra_pkg::DEN_W-1:0]           result_denominator,
	output logic [1:0]                         status
);

	ra_pkg::op_t   op;
	ra_pkg::stat_t stat;
	logic          reply;
	logic          reply_wait;

	// a result is written in the cycle the controller leaves a reply state
	assign reply = stat.out_free && (op == ra_pkg::OP_REPLY_OK || reply_wait);

	ra_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.op       (op)
	);

	// track the reply state that carries the command's own status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_wait <= 1'b0;
		end else if (op == ra_pkg::OP_REJECT || op == ra_pkg::OP_ABS
				|| op == ra_pkg::OP_STORE) begin
			reply_wait <= 1'b1;
		end else if (stat.out_free) begin
			reply_wait <= 1'b0;
		end
	end

	ra_dp #(.WIDTH(WIDTH)) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.op                  (op),
		.reply               (reply),
		.stat                (stat),
		.cmd                 (cmd),
		.operand_numerator   (operand_numerator),
		.operand_denominator (operand_denominator),
		.out_valid           (out_valid),
		.out_stall           (out_stall),
		.result_numerator    (result_numerator),
		.result_denominator  (result_denominator),
		.status              (status)
	);

endmodule
`default_nettype wire
